// ===== rtl/esd_pkg.sv =====
// Shared types and constants for the escaped string decoder.
// No dependencies; imported by esd_core and escaped_string_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

    // decode_mode codes
    localparam logic [1:0] MODE_C       = 2'd0;
    localparam logic [1:0] MODE_SQL_EXT = 2'd1;
    localparam logic [1:0] MODE_SQL_STD = 2'd2;

    // status codes at end of string
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_TRAIL_BSLASH  = 2'd1;
    localparam logic [1:0] ST_LONE_QUOTE    = 2'd2;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic [1:0] status;
    } esd_result_t;

    // results produced by one accepted word, res0 first
    typedef struct packed {
        logic [1:0]  n;
        esd_result_t res1;
        esd_result_t res0;
    } esd_push_t;

endpackage

`default_nettype wire

// ===== rtl/esd_core.sv =====
// Decode core: mode register, scan state and the per-word decode logic.
// Depends on esd_pkg. Emits zero to two results per accepted word.
`timescale 1ns / 1ps
`default_nettype none

module esd_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_wr_data,
    input  wire logic              in_accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    output esd_pkg::esd_push_t     push
);
    import esd_pkg::*;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESC,
        PH_OCT1,
        PH_OCT2,
        PH_QUOTE,
        PH_ERROR
    } phase_t;

    logic [1:0] mode_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] octal_reg, octal_next;

    always_comb
    begin
        logic [1:0]  m;
        phase_t      ph;
        logic [7:0]  ov;
        logic        is_oct;
        logic        plain;
        logic        e1_v, e2_v, e3_v;
        logic [7:0]  e1_b, e2_b, e3_b;
        logic [1:0]  err;
        logic [1:0]  n;
        esd_result_t slot [2];

        m      = (mode_reg == 2'd3) ? MODE_SQL_STD : mode_reg;
        ph     = phase_reg;
        ov     = octal_reg;
        is_oct = in_byte inside {[CH_ZERO:CH_SEVEN]};
        plain  = 1'b0;
        e1_v   = 1'b0;
        e1_b   = '0;
        e2_v   = 1'b0;
        e2_b   = '0;
        e3_v   = 1'b0;
        e3_b   = '0;
        err    = ST_OK;
        n      = 2'd0;
        slot[0] = '0;
        slot[1] = '0;

        case (phase_reg)
            PH_ERROR:
            begin
            end
            PH_ESC:
            begin
                ph   = PH_NORMAL;
                e1_v = 1'b1;
                case (in_byte)
                    CH_LOW_T: e1_b = CH_TAB;
                    CH_LOW_N: e1_b = CH_LF;
                    CH_LOW_R: e1_b = CH_CR;
                    CH_LOW_A: e1_b = CH_BEL;
                    CH_LOW_B: e1_b = CH_BS;
                    default:
                    begin
                        if (is_oct)
                        begin
                            e1_v = 1'b0;
                            ov   = {5'd0, in_byte[2:0]};
                            ph   = PH_OCT1;
                        end
                        else
                        begin
                            e1_b = in_byte;
                        end
                    end
                endcase
            end
            PH_OCT1, PH_OCT2:
            begin
                if (is_oct)
                begin
                    ov = {ov[4:0], in_byte[2:0]};
                    if (phase_reg == PH_OCT1)
                    begin
                        ph = PH_OCT2;
                    end
                    else
                    begin
                        e1_v = 1'b1;
                        e1_b = ov;
                        ph   = PH_NORMAL;
                    end
                end
                else
                begin
                    // run cut short: send the value, then decode this byte
                    e1_v  = 1'b1;
                    e1_b  = ov;
                    ph    = PH_NORMAL;
                    plain = 1'b1;
                end
            end
            PH_QUOTE:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    e1_v = 1'b1;
                    e1_b = in_byte;
                    ph   = PH_NORMAL;
                end
                else
                begin
                    ph = PH_ERROR;
                end
            end
            default:
            begin
                ph    = PH_NORMAL;
                plain = 1'b1;
            end
        endcase

        if (plain)
        begin
            if (m != MODE_C && in_byte == CH_QUOTE)
                ph = PH_QUOTE;
            else if (m != MODE_SQL_STD && in_byte == CH_BSLASH)
                ph = PH_ESC;
            else
            begin
                e2_v = 1'b1;
                e2_b = in_byte;
            end
        end

        if (in_last)
        begin
            case (ph)
                PH_OCT1, PH_OCT2:
                begin
                    e3_v = 1'b1;
                    e3_b = ov;
                end
                PH_ESC:            err = ST_TRAIL_BSLASH;
                PH_QUOTE, PH_ERROR: err = ST_LONE_QUOTE;
                default:           err = ST_OK;
            endcase
        end

        // at most two of the three byte emissions fire for one word
        if (e1_v)
        begin
            slot[n[0]] = '{out_byte: e1_b, byte_valid: 1'b1, done_res: 1'b0, status: ST_OK};
            n = n + 2'd1;
        end
        if (e2_v)
        begin
            slot[n[0]] = '{out_byte: e2_b, byte_valid: 1'b1, done_res: 1'b0, status: ST_OK};
            n = n + 2'd1;
        end
        if (e3_v)
        begin
            slot[n[0]] = '{out_byte: e3_b, byte_valid: 1'b1, done_res: 1'b0, status: ST_OK};
            n = n + 2'd1;
        end

        if (in_last)
        begin
            if (err != ST_OK || n == 2'd0)
            begin
                slot[n[0]] = '{out_byte: 8'd0, byte_valid: 1'b0, done_res: 1'b1, status: err};
                n = n + 2'd1;
            end
            else
            begin
                slot[n[0] ^ 1'b1].done_res = 1'b1;
            end
            ph = PH_NORMAL;
            ov = 8'd0;
        end

        phase_next = ph;
        octal_next = ov;
        push.n     = in_accept ? n : 2'd0;
        push.res0  = slot[0];
        push.res1  = slot[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_C;
            phase_reg <= PH_NORMAL;
            octal_reg <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (in_accept)
            begin
                phase_reg <= phase_next;
                octal_reg <= octal_next;
            end
        end
    end

    a_last_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_last) |->
            (push.n == 2'd1 && push.res0.done_res) || (push.n == 2'd2 && push.res1.done_res))
        else $error("final word of a string without a done result");

    a_no_done_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !in_last) |->
            (push.n == 2'd0 || !push.res0.done_res) && (push.n != 2'd2 || !push.res1.done_res))
        else $error("done result before the end of a string");

    a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_last) |=> (phase_reg == PH_NORMAL && octal_reg == 8'd0))
        else $error("scan state not cleared after end of string");

endmodule

`default_nettype wire

// ===== rtl/escaped_string_decoder_top.sv =====
// Escaped string decoder top: stream ports, decode core and result queue.
// Depends on esd_pkg and esd_core.
//
// Usage:
//   Input stream s_*: one raw byte of the escaped string body per word,
//   s_tlast marks the final byte of a string.
//   Output stream m_*: one result per word; m_tdata is the decoded byte,
//   m_tuser carries byte_valid and the end status, m_tlast marks the final
//   result of a string. On an error status, bytes already sent for that
//   string must be dropped downstream.
//   cfg_wr_en / cfg_wr_data write decode_mode (0 C, 1 SQL extended,
//   2 SQL standard); write only while the block is idle.
// Timing:
//   Results enter the result queue when the input word is taken. One input
//   word per cycle is taken while the result queue has room for two
//   results; a word yielding two results (a cut octal run) takes an extra
//   output slot, absorbed by the FIFO_DEPTH queue.
// Reset: clears mode to C, scan state, and empties the queue.
// Stall: while m_tready is low, results collect in the queue and s_tready
//   drops once fewer than two free entries remain.
`timescale 1ns / 1ps
`default_nettype none

module escaped_string_decoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // config
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // last
    // output stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [2:0]      m_tuser,   // [0] byte_valid, [2:1] status
    output logic            m_tlast    // done_res
);
    import esd_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] ROOM_LIM = CW'(FIFO_DEPTH - 2);
    localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);

    esd_push_t   push;
    esd_result_t q_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          s_accept;
    logic          pop;
    logic [PW-1:0] wr_ptr_inc;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    assign s_tready = (count_reg <= ROOM_LIM);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;

    assign m_tdata = q_reg[rd_ptr_reg].out_byte;
    assign m_tuser = {q_reg[rd_ptr_reg].status, q_reg[rd_ptr_reg].byte_valid};
    assign m_tlast = q_reg[rd_ptr_reg].done_res;

    esd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (s_accept),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .push        (push)
    );

    always_comb
    begin
        wr_ptr_inc  = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push.n == 2'd1)
            wr_ptr_next = wr_ptr_inc;
        else if (push.n == 2'd2)
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            q_reg[wr_ptr_reg] <= push.res0;
        if (push.n == 2'd2)
            q_reg[wr_ptr_inc] <= push.res1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("result queue overflow");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.n == 2'd0) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("queue count wrong after pop");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> (CW'(push.n) + count_reg <= DEPTH_C + CW'(pop)))
        else $error("push into a full queue");

endmodule

`default_nettype wire
